/* rtl/zbct_pkg.sv */
// Shared types, codes and sizes of the zoned block translator.
// Used by every module under rtl; depends on nothing.
package zbct_pkg;

  localparam int MAX_TRACKS = 256;
  localparam int TRACK_BITS = $clog2(MAX_TRACKS);
  localparam int BLOCK_BITS = 16;

  // One more than the block width, plus a carry bit for the load check.
  localparam logic [BLOCK_BITS+1:0] BLOCK_CAP = (BLOCK_BITS + 2)'(1) << BLOCK_BITS;

  localparam logic [1:0] ACT_LOAD   = 2'd0;
  localparam logic [1:0] ACT_FIND   = 2'd1;
  localparam logic [1:0] ACT_CHS    = 2'd2;
  localparam logic [1:0] ACT_TRKSEC = 2'd3;

  localparam logic [1:0] KIND_LOAD   = 2'd0;
  localparam logic [1:0] KIND_FIND   = 2'd1;
  localparam logic [1:0] KIND_LOOKUP = 2'd2;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_BAD_BLOCK  = 3'd1;
  localparam logic [2:0] ST_BAD_TRACK  = 3'd2;
  localparam logic [2:0] ST_BAD_SECTOR = 3'd3;
  localparam logic [2:0] ST_BAD_CYL    = 3'd4;
  localparam logic [2:0] ST_BAD_HEAD   = 3'd5;
  localparam logic [2:0] ST_ORDER      = 3'd6;

  localparam logic REG_HEAD_COUNT     = 1'b0;
  localparam logic REG_CYLINDER_COUNT = 1'b1;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] block_number;
    logic [7:0]  track_index;
    logic [7:0]  cylinder_index;
    logic [3:0]  head_index;
    logic [7:0]  sector_index;
    logic [7:0]  sector_count;
  } zbct_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] block_out;
    logic [7:0]  track_out;
    logic [7:0]  sector_out;
    logic [7:0]  cylinder_out;
    logic [3:0]  head_out;
  } zbct_result_t;

  // A classified item as it waits between front and back.
  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  pre_status;
    logic [15:0] block;
    logic [11:0] track;
    logic [7:0]  sector;
    logic [7:0]  count;
  } zbct_work_t;

endpackage

/* rtl/zoned_block_chs_translator_top.sv */
// Top level of the zoned block translator: front end, queue and back end.
// Depends on zbct_pkg, zbct_front, zbct_queue and zbct_back.

// Users start here. Items are taken on a rising edge with start high and busy
// low; busy is high only while the two-entry queue in front of the back end is
// full. Every item gives exactly one result beat, shown for a single cycle with
// done high; the receiver cannot hold it, so it must take every beat as it
// comes. Results leave in the order items came in. A cylinder-head-sector or
// track-sector lookup makes one table read, then the bit-serial divide by the
// head count. In a block-to-address search each probe of the binary search
// costs one read of the single-port track table and one compare. Configuration
// writes are always ready and must only be issued while no item is pending.
// The track table has no reset; only loaded tracks are ever used.
module zoned_block_chs_translator_top import zbct_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  zbct_item_t    item,
  output logic          done,
  output zbct_result_t  result,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic          cfg_index,
  input  logic [8:0]    cfg_data
);

  zbct_work_t work;
  zbct_work_t head_data;
  logic [4:0] heads;
  logic       head_valid;
  logic       pop;
  logic       full;

  assign cfg_ready = 1'b1;
  assign busy      = full;

  // The front end classifies the item and checks cylinder and head ranges.
  zbct_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item),
    .work      (work),
    .heads     (heads)
  );

  zbct_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (start && !full),
    .push_data  (work),
    .pop        (pop),
    .head_valid (head_valid),
    .head_data  (head_data),
    .full       (full)
  );

  // The back end owns the track table and all state that loads change.
  zbct_back u_back (
    .clk        (clk),
    .rst        (rst),
    .heads      (heads),
    .head_valid (head_valid),
    .head_data  (head_data),
    .pop        (pop),
    .done       (done),
    .result     (result)
  );

endmodule

/* rtl/zbct_front.sv */
// Front end: configuration registers and classification of incoming items.
// Depends on zbct_pkg.
module zbct_front import zbct_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_valid,
  input  logic         cfg_index,
  input  logic [8:0]   cfg_data,
  input  zbct_item_t   item,
  output zbct_work_t   work,
  output logic [4:0]   heads
);

  logic [4:0] head_count;
  logic [8:0] cylinder_count;
  logic [12:0] chs_track;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_count     <= 5'd2;
      cylinder_count <= 9'd80;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_HEAD_COUNT:     head_count     <= cfg_data[4:0];
        REG_CYLINDER_COUNT: cylinder_count <= cfg_data;
        default: ;
      endcase
    end
  end

  // Head counts outside 1..16 are clamped.
  always_comb begin
    if (head_count == 5'd0) heads = 5'd1;
    else if (head_count > 5'd16) heads = 5'd16;
    else heads = head_count;
  end

  assign chs_track = item.cylinder_index * heads + {9'd0, item.head_index};

  always_comb begin
    work.pre_status = ST_OK;
    work.block      = item.block_number;
    work.sector     = item.sector_index;
    work.count      = item.sector_count;
    work.track      = {4'd0, item.track_index};
    unique case (item.action)
      ACT_LOAD: work.kind = KIND_LOAD;
      ACT_FIND: work.kind = KIND_FIND;
      ACT_CHS: begin
        work.kind  = KIND_LOOKUP;
        work.track = chs_track[11:0];
        if ({1'b0, item.cylinder_index} >= cylinder_count) work.pre_status = ST_BAD_CYL;
        else if ({1'b0, item.head_index} >= heads) work.pre_status = ST_BAD_HEAD;
      end
      default: work.kind = KIND_LOOKUP;
    endcase
  end

endmodule

/* rtl/zbct_queue.sv */
// Two-entry queue of classified items between front and back.
// Depends on zbct_pkg.
module zbct_queue import zbct_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  zbct_work_t  push_data,
  input  logic        pop,
  output logic        head_valid,
  output zbct_work_t  head_data,
  output logic        full
);

  zbct_work_t entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign head_valid = (fill != 2'd0);
  assign full       = (fill == 2'd2);
  assign head_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

/* rtl/zbct_back.sv */
// Back end: track table memory, binary search, and the head divider.
// Depends on zbct_pkg.
module zbct_back import zbct_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic [4:0]    heads,
  input  logic          head_valid,
  input  zbct_work_t    head_data,
  output logic          pop,
  output logic          done,
  output zbct_result_t  result
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FSTEP = 3'd1;
  localparam logic [2:0] S_FCMP  = 3'd2;
  localparam logic [2:0] S_LCHK  = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;

  // Each entry holds the track's first block above its sector count. The first
  // block is one bit wider than a block number, since an empty track loaded
  // after a full 2^16 blocks starts at 65536.
  logic [BLOCK_BITS+8:0] mem [MAX_TRACKS];
  logic [BLOCK_BITS+8:0] rd_data;
  logic [TRACK_BITS-1:0] rd_addr;
  logic                  mem_we;

  logic [2:0]            state;
  zbct_work_t            cur;
  logic [TRACK_BITS:0]   loaded;
  logic [BLOCK_BITS:0]   total;
  logic [TRACK_BITS-1:0] lo;
  logic [TRACK_BITS-1:0] hi;
  logic [TRACK_BITS-1:0] mid;
  logic [BLOCK_BITS-1:0] lo_val;
  logic [7:0]            quot;
  logic [4:0]            rem;
  logic [2:0]            step;
  logic [15:0]           out_block;
  logic [7:0]            out_sector;

  logic [TRACK_BITS:0]   mid_sum;
  logic [TRACK_BITS:0]   ld_loaded;
  logic [BLOCK_BITS:0]   ld_total;
  logic [BLOCK_BITS+1:0] ld_sum;
  logic                  ld_order_ok;
  logic                  ld_fit;
  logic [BLOCK_BITS:0]   rd_first;
  logic [7:0]            rd_size;
  logic [5:0]            trial;
  logic                  trial_ge;
  logic [4:0]            rem_next;
  logic [7:0]            quot_next;

  function automatic zbct_result_t fail(input logic [2:0] code);
    zbct_result_t r;
    r        = '0;
    r.status = code;
    return r;
  endfunction

  assign rd_first = rd_data[BLOCK_BITS+8:8];
  assign rd_size  = rd_data[7:0];
  assign mid_sum  = {1'b0, lo} + {1'b0, hi} + (TRACK_BITS + 1)'(1);

  // A load of track 0 restarts the table before it is checked.
  assign ld_loaded   = (head_data.track == 12'd0) ? '0 : loaded;
  assign ld_total    = (head_data.track == 12'd0) ? '0 : total;
  assign ld_sum      = {1'b0, ld_total} + (BLOCK_BITS + 2)'(head_data.count);
  assign ld_order_ok = (head_data.track == 12'(ld_loaded));
  assign ld_fit      = (ld_sum <= BLOCK_CAP);

  assign pop    = (state == S_IDLE) && head_valid;
  assign mem_we = pop && (head_data.kind == KIND_LOAD) && ld_order_ok && ld_fit;
  assign rd_addr = (state == S_FSTEP) ? mid_sum[TRACK_BITS:1]
                                      : head_data.track[TRACK_BITS-1:0];

  assign trial     = {rem, quot[7]};
  assign trial_ge  = (trial >= {1'b0, heads});
  assign rem_next  = trial_ge ? 5'(trial - {1'b0, heads}) : trial[4:0];
  assign quot_next = {quot[6:0], trial_ge};

  always_ff @(posedge clk) begin
    if (mem_we) mem[head_data.track[TRACK_BITS-1:0]] <= {ld_total, head_data.count};
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      loaded <= '0;
      total  <= '0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (head_valid) begin
            cur <= head_data;
            unique case (head_data.kind)
              KIND_LOAD: begin
                done <= 1'b1;
                // A failed load keeps the table, apart from the track 0 restart.
                if (!ld_order_ok) begin
                  loaded <= ld_loaded;
                  total  <= ld_total;
                  result <= fail(ST_ORDER);
                end else if (!ld_fit) begin
                  loaded <= ld_loaded;
                  total  <= ld_total;
                  result <= fail(ST_BAD_BLOCK);
                end else begin
                  total  <= ld_sum[BLOCK_BITS:0];
                  loaded <= (TRACK_BITS + 1)'(head_data.track) + (TRACK_BITS + 1)'(1);
                  result <= '{status: ST_OK, block_out: ld_total[15:0],
                              track_out: head_data.track[7:0], sector_out: 8'd0,
                              cylinder_out: 8'd0, head_out: 4'd0};
                end
              end
              KIND_FIND: begin
                if ({1'b0, head_data.block} >= total) begin
                  done   <= 1'b1;
                  result <= fail(ST_BAD_BLOCK);
                end else begin
                  lo     <= '0;
                  lo_val <= '0;
                  hi     <= TRACK_BITS'(loaded - (TRACK_BITS + 1)'(1));
                  state  <= S_FSTEP;
                end
              end
              default: begin
                if (head_data.pre_status != ST_OK) begin
                  done   <= 1'b1;
                  result <= fail(head_data.pre_status);
                end else if (head_data.track >= 12'(loaded)) begin
                  done   <= 1'b1;
                  result <= fail(ST_BAD_TRACK);
                end else begin
                  state <= S_LCHK;
                end
              end
            endcase
          end
        end
        S_FSTEP: begin
          if (lo == hi) begin
            quot       <= 8'(lo);
            rem        <= 5'd0;
            step       <= 3'd0;
            out_block  <= cur.block;
            out_sector <= 8'(cur.block - lo_val);
            state      <= S_DIV;
          end else begin
            mid   <= mid_sum[TRACK_BITS:1];
            state <= S_FCMP;
          end
        end
        S_FCMP: begin
          if (rd_first <= {1'b0, cur.block}) begin
            lo     <= mid;
            lo_val <= rd_first[BLOCK_BITS-1:0];
          end else begin
            hi <= mid - TRACK_BITS'(1);
          end
          state <= S_FSTEP;
        end
        S_LCHK: begin
          if (cur.sector >= rd_size) begin
            done   <= 1'b1;
            result <= fail(ST_BAD_SECTOR);
            state  <= S_IDLE;
          end else begin
            lo         <= cur.track[TRACK_BITS-1:0];
            quot       <= cur.track[7:0];
            rem        <= 5'd0;
            step       <= 3'd0;
            out_block  <= rd_first[BLOCK_BITS-1:0] + 16'(cur.sector);
            out_sector <= cur.sector;
            state      <= S_DIV;
          end
        end
        S_DIV: begin
          quot <= quot_next;
          rem  <= rem_next;
          step <= step + 3'd1;
          if (step == 3'd7) begin
            done   <= 1'b1;
            result <= '{status: ST_OK, block_out: out_block, track_out: 8'(lo),
                        sector_out: out_sector, cylinder_out: quot_next,
                        head_out: rem_next[3:0]};
            state  <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
